// File: hw/rtl/lst_pkg.sv
// Shared types and constants for the line sensor tracker.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package lst_pkg;

  // Field widths of one sensor frame and one result.
  localparam int LINE_W   = 16;
  localparam int COUNT_W  = 2;
  localparam int DIR_W    = 2;
  localparam int TRAVEL_W = 12;
  localparam int KIND_W   = 2;
  localparam int DIST_W   = 16;
  localparam int RUN_W    = 8;

  // Line positions carried per frame and lines that take part in the search.
  localparam int NUM_LANES = 3;
  localparam int MAX_LINES = 3;
  localparam int IDX_W     = $clog2(NUM_LANES);
  localparam int USE_W     = $clog2(MAX_LINES + 1);

  // Stream word widths, padded to whole bytes.
  localparam int IN_W  = 64;
  localparam int OUT_W = 40;

  // Configuration port.
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;

  localparam logic [CFG_IDX_W-1:0] REG_COUNT_FILTER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_WAIT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BRAKE_WAIT   = 2'd2;

  localparam logic [RUN_W-1:0]  COUNT_FILTER_RST = 8'd3;
  localparam logic [DIST_W-1:0] ACCEL_WAIT_RST   = 16'd1100;
  localparam logic [DIST_W-1:0] BRAKE_WAIT_RST   = 16'd3100;

  // Result of the nearest-line merge.
  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] idx;
  } near_sel_t;

endpackage

// File: hw/rtl/line_sensor_tracker_unit.sv
// Top level of the line sensor tracker: frame stream in, tracking result out.
// Depends on lst_pkg, lst_lane, lst_merge and lst_out_buf.
`timescale 1ns / 1ps

// Usage
//   Each word on the s_ side is one line-sensor frame. For every accepted frame the
//   block emits exactly one result word on the m_ side, in order.
//   The three line positions go to three lanes that each compute the distance to the
//   previously tracked line; a merge stage picks the nearest. In the same cycle the
//   line count is debounced, a line is chosen by direction and the track-type phase
//   machine (slow, accel, fast, brake) advances on the debounced count and the
//   remaining travel distance.
// Throughput
//   A result is registered in the output buffer before it shows on m_tvalid.
//   One frame is taken per cycle while the buffer has room; the state update is
//   combinational; the next frame needs the tracked line and counters of this one.
// Stall
//   Results go into a two-entry output buffer, so the block keeps taking frames while
//   one result waits. With both entries full, s_tready drops until m_tready frees one.
// Reset
//   rst is synchronous and active high. It restores the configuration registers to
//   3, 1100 and 3100, clears the tracker state and empties the output buffer.
//   Write configuration via cfg_we/cfg_index/cfg_data only while idle (unenforced).

module line_sensor_tracker_unit (
  input  logic                          clk,
  input  logic                          rst,
  // Frame input. s_tdata, low bit up: line_count[2], first_line_mm[16],
  // second_line_mm[16], third_line_mm[16], direction[2], travel_mm[12].
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [lst_pkg::IN_W-1:0]      s_tdata,
  // Result output. m_tdata, low bit up: filtered_count[2], nearest_line_mm[16],
  // chosen_line_mm[16], track_kind[2], zero padding[4].
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [lst_pkg::OUT_W-1:0]     m_tdata,
  // Configuration write port.
  input  logic                          cfg_we,
  input  logic [lst_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lst_pkg::CFG_W-1:0]     cfg_data
);
  import lst_pkg::*;

  localparam logic [1:0] PH_SLOW  = 2'd0;
  localparam logic [1:0] PH_ACCEL = 2'd1;
  localparam logic [1:0] PH_FAST  = 2'd2;
  localparam logic [1:0] PH_BRAKE = 2'd3;

  localparam logic [KIND_W-1:0] KIND_SINGLE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ACCEL  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_BRAKE  = 2'd2;

  localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd2;

  // Configuration registers.
  logic [RUN_W-1:0]  count_filter_length;
  logic [DIST_W-1:0] accel_wait_mm;
  logic [DIST_W-1:0] brake_wait_mm;

  // Tracker state.
  logic signed [LINE_W-1:0] last_nearest, last_nearest_next;
  logic signed [LINE_W-1:0] last_chosen, last_chosen_next;
  logic [COUNT_W-1:0]       previous_count, previous_count_next;
  logic [RUN_W-1:0]         same_count_run, same_count_run_next;
  logic [COUNT_W-1:0]       debounced_count, debounced_count_next;
  logic [1:0]               race_phase, race_phase_next;
  logic [DIST_W-1:0]        distance_left, distance_left_next;
  logic [KIND_W-1:0]        current_kind, current_kind_next;

  // Unpacked frame fields.
  logic [COUNT_W-1:0]       line_count;
  logic signed [LINE_W-1:0] lines [NUM_LANES];
  logic [DIR_W-1:0]         direction;
  logic [TRAVEL_W-1:0]      travel_mm;

  logic                     accept;
  logic                     space;
  logic [DIST_W-1:0]        lane_gap [NUM_LANES];
  logic [USE_W-1:0]         usable;
  near_sel_t                sel;
  logic [DIST_W-1:0]        dist_after_travel;
  logic [OUT_W-1:0]         result;

  assign line_count = s_tdata[1:0];
  assign lines[0]   = s_tdata[17:2];
  assign lines[1]   = s_tdata[33:18];
  assign lines[2]   = s_tdata[49:34];
  assign direction  = s_tdata[51:50];
  assign travel_mm  = s_tdata[63:52];

  assign s_tready = space;
  assign accept   = s_tvalid && s_tready;

  // One distance lane per line position.
  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    lst_lane u_lane (
      .line_mm (lines[g]),
      .ref_mm  (last_nearest),
      .gap     (lane_gap[g])
    );
  end

  // Only the first MAX_LINES lines of the frame take part in the search.
  assign usable = (int'(line_count) > MAX_LINES) ? USE_W'(MAX_LINES) : USE_W'(line_count);

  lst_merge u_merge (
    .gap    (lane_gap),
    .usable (usable),
    .sel    (sel)
  );

  // Travel distance counts down and stops at zero.
  assign dist_after_travel = (distance_left > DIST_W'(travel_mm))
                           ? distance_left - DIST_W'(travel_mm) : '0;

  always_comb begin
    previous_count_next  = previous_count;
    same_count_run_next  = same_count_run;
    debounced_count_next = debounced_count;
    last_nearest_next    = last_nearest;
    last_chosen_next     = last_chosen;
    race_phase_next      = race_phase;
    current_kind_next    = current_kind;
    distance_left_next   = dist_after_travel;

    // Debounce: a count is adopted only once it has repeated often enough.
    if (line_count == previous_count) begin
      if (same_count_run != {RUN_W{1'b1}}) begin
        same_count_run_next = same_count_run + 1'b1;
      end
      if (same_count_run_next >= count_filter_length) begin
        debounced_count_next = line_count;
      end
    end else begin
      previous_count_next = line_count;
      same_count_run_next = RUN_W'(1);
    end

    if (sel.hit) begin
      last_nearest_next = lines[sel.idx];
    end

    // Choice by direction; no lines, too many lines or an unknown direction keep
    // the previous choice.
    if ((line_count != '0) && (int'(line_count) <= MAX_LINES) && (direction <= DIR_RIGHT))
    begin
      if (line_count == COUNT_W'(1)) begin
        last_chosen_next = lines[0];
      end else if (line_count == COUNT_W'(2)) begin
        last_chosen_next = (direction == DIR_RIGHT) ? lines[1] : lines[0];
      end else begin
        last_chosen_next = lines[direction];
      end
    end

    // Track-type machine, driven by the debounced count of this frame.
    unique case (race_phase)
      PH_SLOW: begin
        if (debounced_count_next == COUNT_W'(3)) begin
          distance_left_next = accel_wait_mm;
          race_phase_next    = PH_ACCEL;
          current_kind_next  = KIND_ACCEL;
        end
      end
      PH_ACCEL: begin
        if ((debounced_count_next == COUNT_W'(1)) && (dist_after_travel == '0)) begin
          race_phase_next   = PH_FAST;
          current_kind_next = KIND_SINGLE;
        end
      end
      PH_FAST: begin
        if (debounced_count_next == COUNT_W'(3)) begin
          distance_left_next = brake_wait_mm;
          race_phase_next    = PH_BRAKE;
          current_kind_next  = KIND_BRAKE;
        end
      end
      PH_BRAKE: begin
        if ((debounced_count_next == COUNT_W'(1)) && (dist_after_travel == '0)) begin
          race_phase_next   = PH_SLOW;
          current_kind_next = KIND_SINGLE;
        end
      end
      default: begin
        race_phase_next = PH_SLOW;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_filter_length <= COUNT_FILTER_RST;
      accel_wait_mm       <= ACCEL_WAIT_RST;
      brake_wait_mm       <= BRAKE_WAIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COUNT_FILTER: count_filter_length <= cfg_data[RUN_W-1:0];
        REG_ACCEL_WAIT:   accel_wait_mm       <= cfg_data[DIST_W-1:0];
        REG_BRAKE_WAIT:   brake_wait_mm       <= cfg_data[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_nearest    <= '0;
      last_chosen     <= '0;
      previous_count  <= '0;
      same_count_run  <= '0;
      debounced_count <= '0;
      race_phase      <= PH_SLOW;
      distance_left   <= '0;
      current_kind    <= KIND_SINGLE;
    end else if (accept) begin
      last_nearest    <= last_nearest_next;
      last_chosen     <= last_chosen_next;
      previous_count  <= previous_count_next;
      same_count_run  <= same_count_run_next;
      debounced_count <= debounced_count_next;
      race_phase      <= race_phase_next;
      distance_left   <= distance_left_next;
      current_kind    <= current_kind_next;
    end
  end

  assign result = {4'b0000, current_kind_next, last_chosen_next, last_nearest_next,
                   debounced_count_next};

  lst_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (result),
    .space     (space),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  // Every accepted frame leaves a result word waiting on the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> m_tvalid)
    else $error("accepted frame produced no result word");

  // The track kind always matches the phase of the machine.
  a_kind_phase: assert property (@(posedge clk) disable iff (rst)
    ((race_phase != PH_ACCEL) || (current_kind == KIND_ACCEL)) &&
    ((race_phase != PH_BRAKE) || (current_kind == KIND_BRAKE)) &&
    (((race_phase != PH_SLOW) && (race_phase != PH_FAST)) ||
      (current_kind == KIND_SINGLE)))
    else $error("track kind does not match phase");

  // After any frame the repeat counter is at least one.
  a_run_nonzero: assert property (@(posedge clk) disable iff (rst)
    accept |=> (same_count_run != '0))
    else $error("repeat counter zero after a frame");

  // Input stalls only while a result is waiting.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with no pending result");

endmodule

// File: hw/rtl/lst_lane.sv
// One lane of the nearest-line search: distance of one line to the tracked line.
// Depends on lst_pkg.
`timescale 1ns / 1ps

module lst_lane (
  input  logic signed [lst_pkg::LINE_W-1:0] line_mm,
  input  logic signed [lst_pkg::LINE_W-1:0] ref_mm,
  output logic        [lst_pkg::DIST_W-1:0] gap
);
  import lst_pkg::*;

  logic signed [LINE_W:0] diff;
  logic        [LINE_W:0] mag;

  // The difference is taken one bit wider so that it cannot wrap.
  assign diff = {line_mm[LINE_W-1], line_mm} - {ref_mm[LINE_W-1], ref_mm};
  assign mag  = diff[LINE_W] ? (~diff + 1'b1) : diff;
  assign gap  = mag[DIST_W-1:0];

endmodule

// File: hw/rtl/lst_merge.sv
// Merge stage: picks the lane with the smallest distance among the usable lanes.
// Depends on lst_pkg.
`timescale 1ns / 1ps

module lst_merge (
  input  logic [lst_pkg::DIST_W-1:0] gap [lst_pkg::NUM_LANES],
  input  logic [lst_pkg::USE_W-1:0]  usable,
  output lst_pkg::near_sel_t         sel
);
  import lst_pkg::*;

  always_comb begin
    logic [DIST_W-1:0] best;
    best    = gap[0];
    sel.idx = '0;
    sel.hit = (usable != '0);
    // Strict compare, so on a tie the lower lane keeps the win.
    for (int i = 1; i < NUM_LANES; i++) begin
      if ((int'(usable) > i) && (gap[i] < best)) begin
        best    = gap[i];
        sel.idx = IDX_W'(i);
      end
    end
  end

endmodule

// File: hw/rtl/lst_out_buf.sv
// Two-entry output buffer: a result register plus a skid register.
// Depends on lst_pkg.
`timescale 1ns / 1ps

module lst_out_buf (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  logic [lst_pkg::OUT_W-1:0] push_data,
  output logic                      space,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [lst_pkg::OUT_W-1:0] m_tdata
);
  import lst_pkg::*;

  logic             valid0;
  logic             valid1;
  logic [OUT_W-1:0] data0;
  logic [OUT_W-1:0] data1;
  logic             pop;

  assign pop      = valid0 && m_tready;
  assign space    = !valid1;
  assign m_tvalid = valid0;
  assign m_tdata  = data0;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid0 <= 1'b0;
      valid1 <= 1'b0;
    end else if (pop) begin
      if (valid1) begin
        data0  <= data1;
        valid1 <= push;
        data1  <= push_data;
      end else begin
        valid0 <= push;
        data0  <= push_data;
      end
    end else if (push) begin
      if (!valid0) begin
        valid0 <= 1'b1;
        data0  <= push_data;
      end else begin
        valid1 <= 1'b1;
        data1  <= push_data;
      end
    end
  end

  // A full buffer never takes a word without handing one out.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (valid1 && !pop) |-> !push)
    else $error("output buffer overflow");

  // The skid entry is only ever used behind a valid head entry.
  a_skid_order: assert property (@(posedge clk) disable iff (rst)
    valid1 |-> valid0)
    else $error("skid entry valid without head entry");

  // A waiting head word is not dropped.
  a_head_held: assert property (@(posedge clk) disable iff (rst)
    (valid0 && !m_tready) |=> valid0)
    else $error("head word lost while stalled");

endmodule
